/* hdl/ptcr_pkg.sv */
// Shared types, constants and helpers for the proportional text cursor renderer.
// Used by every module in the hdl folder; depends on nothing.
package ptcr_pkg;

  // Cursor coordinate width and fixed port widths.
  localparam int COORD_WIDTH  = 11;
  localparam int OUT_COORD_W  = 11;
  localparam int CHAR_W       = 8;
  localparam int GLYPH_W      = 64;
  localparam int MASK_W       = 8;
  localparam int COLOUR_W     = 16;
  localparam int LIMIT_W      = 10;

  // Glyph geometry.
  localparam int GLYPH_ROWS   = 8;
  localparam int ROW_IDX_W    = 3;
  localparam int ADV_W        = 4;

  // Request queue between the front and back parts.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_COLUMN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ROW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INK_COLOUR = 2'd2;

  // Register reset values.
  localparam logic [LIMIT_W-1:0]  MAX_COLUMN_RST = 10'd320;
  localparam logic [LIMIT_W-1:0]  MAX_ROW_RST    = 10'd240;
  localparam logic [COLOUR_W-1:0] INK_COLOUR_RST = 16'hFFFF;

  // Character and command codes.
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic              CMD_GLYPH_ROW  = 1'b0;
  localparam logic              CMD_SCROLL     = 1'b1;

  // Line pitch and the stand-in mask for a blank glyph.
  localparam logic [COORD_WIDTH-1:0] LINE_STEP  = COORD_WIDTH'(8);
  localparam logic [MASK_W-1:0]      BLANK_MASK = 8'h0F;

  // One classified character, handed from front to back.
  typedef struct packed {
    logic                   scroll;
    logic [COORD_WIDTH-1:0] col;
    logic [COORD_WIDTH-1:0] row;
    logic [GLYPH_W-1:0]     glyph;
    logic [COLOUR_W-1:0]    colour;
  } ptcr_entry_t;

  // Proportional advance: highest set column over all rows plus two.
  function automatic logic [ADV_W-1:0] glyph_advance(input logic [MASK_W-1:0] cum);
    logic [MASK_W-1:0] bits;
    logic [ADV_W-1:0]  high;
    bits = (cum == '0) ? BLANK_MASK : cum;
    high = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (bits[b]) high = ADV_W'(b);
    end
    return high + ADV_W'(2);
  endfunction

endpackage

/* hdl/ptcr_front.sv */
// Front part: configuration registers, text cursor and per-character classification.
// Depends on ptcr_pkg; feeds ptcr_fifo.
module ptcr_front import ptcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CHAR_W-1:0]      char_code_i,
  input  logic [GLYPH_W-1:0]     glyph_bits_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output ptcr_entry_t            push_entry_o
);

  logic [LIMIT_W-1:0]     max_column_q, max_row_q;
  logic [COLOUR_W-1:0]    ink_colour_q;
  logic [COORD_WIDTH-1:0] col_q, col_d, row_q, row_d;
  logic                   accept;
  logic                   newline, wrap, scroll;
  logic [COORD_WIDTH-1:0] col_nl, col_draw, row_step, row_wrap, row_draw;
  logic [MASK_W-1:0]      cum;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_column_q <= MAX_COLUMN_RST;
      max_row_q    <= MAX_ROW_RST;
      ink_colour_q <= INK_COLOUR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_COLUMN: max_column_q <= cfg_data_i[LIMIT_W-1:0];
        REG_MAX_ROW:    max_row_q    <= cfg_data_i[LIMIT_W-1:0];
        REG_INK_COLOUR: ink_colour_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // The queue sets the pace of the input side.
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;

  // Newline and wrap each move down one line; the two steps add up.
  always_comb begin
    newline  = (char_code_i == CHAR_NEWLINE);
    col_nl   = newline ? '0 : col_q;
    wrap     = (col_nl >= COORD_WIDTH'(max_column_q));
    row_step = {(COORD_WIDTH-4)'(0), {newline && wrap, newline != wrap}, 2'b00} << 1;
    row_wrap = row_q + row_step;
    scroll   = (row_wrap >= COORD_WIDTH'(max_row_q));
    row_draw = scroll ? (row_wrap - LINE_STEP) : row_wrap;
    col_draw = (wrap || scroll) ? '0 : col_nl;
  end

  // Union of all glyph rows sets the proportional advance.
  always_comb begin
    cum = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      cum = cum | glyph_bits_i[r*MASK_W +: MASK_W];
    end
  end

  assign col_d = accept ? (col_draw + COORD_WIDTH'(glyph_advance(cum))) : col_q;
  assign row_d = accept ? row_draw : row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Request handed to the back part.
  always_comb begin
    push_entry_o.scroll = scroll;
    push_entry_o.col    = col_draw;
    push_entry_o.row    = row_draw;
    push_entry_o.glyph  = glyph_bits_i;
    push_entry_o.colour = ink_colour_q;
  end

endmodule

/* hdl/ptcr_fifo.sv */
// Short request queue between the front and back parts.
// Depends on ptcr_pkg for the entry type and depth.
module ptcr_fifo import ptcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  ptcr_entry_t push_entry_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output ptcr_entry_t pop_entry_o
);

  ptcr_entry_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Pointer advance with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    count_d = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

/* hdl/ptcr_back.sv */
// Back part: walks one queued character into its scroll and glyph-row results.
// Depends on ptcr_pkg; drains ptcr_fifo and drives the result port register.
module ptcr_back import ptcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  ptcr_entry_t            pop_entry_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   command_kind_o,
  output logic [OUT_COORD_W-1:0] pixel_x_o,
  output logic [OUT_COORD_W-1:0] pixel_y_o,
  output logic [MASK_W-1:0]      pixel_mask_o,
  output logic [COLOUR_W-1:0]    paint_colour_o,
  output logic                   last_of_char_o
);

  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(GLYPH_ROWS - 1);

  logic [ROW_IDX_W-1:0] row_idx_q, row_idx_d;
  logic                 scroll_done_q, scroll_done_d;
  logic                 out_valid_q, out_valid_d;
  logic                 show_scroll, out_load;
  logic                 kind_q, last_q;
  logic [COORD_WIDTH-1:0] x_q, y_q;
  logic [MASK_W-1:0]    mask_q;
  logic [COLOUR_W-1:0]  colour_q;

  // The scroll request, if any, goes out before the first glyph row.
  assign show_scroll = pop_entry_i.scroll && !scroll_done_q;
  assign out_load    = pop_valid_i && (!out_valid_q || out_ready_i);
  assign pop_ready_o = out_load && !show_scroll && (row_idx_q == LAST_ROW);

  // Step through the character's results.
  always_comb begin
    row_idx_d     = row_idx_q;
    scroll_done_d = scroll_done_q;
    if (out_load) begin
      if (show_scroll) begin
        scroll_done_d = 1'b1;
      end else if (row_idx_q == LAST_ROW) begin
        row_idx_d     = '0;
        scroll_done_d = 1'b0;
      end else begin
        row_idx_d = row_idx_q + ROW_IDX_W'(1);
      end
    end
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_idx_q     <= '0;
      scroll_done_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      row_idx_q     <= row_idx_d;
      scroll_done_q <= scroll_done_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Result register, loaded when empty or being taken.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (show_scroll) begin
        kind_q   <= CMD_SCROLL;
        x_q      <= '0;
        y_q      <= pop_entry_i.row;
        mask_q   <= '0;
        colour_q <= '0;
        last_q   <= 1'b0;
      end else begin
        kind_q   <= CMD_GLYPH_ROW;
        x_q      <= pop_entry_i.col;
        y_q      <= pop_entry_i.row + COORD_WIDTH'(row_idx_q);
        mask_q   <= pop_entry_i.glyph[{row_idx_q, 3'b000} +: MASK_W];
        colour_q <= pop_entry_i.colour;
        last_q   <= (row_idx_q == LAST_ROW);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_kind_o = kind_q;
  assign pixel_x_o      = OUT_COORD_W'(x_q);
  assign pixel_y_o      = OUT_COORD_W'(y_q);
  assign pixel_mask_o   = mask_q;
  assign paint_colour_o = colour_q;
  assign last_of_char_o = last_q;

endmodule

/* hdl/proportional_text_cursor_renderer.sv */
// Top level of the proportional text cursor renderer.
// Depends on ptcr_pkg, ptcr_front, ptcr_fifo and ptcr_back.
//
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+-----------------------------------------
//   cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//   in       | in_valid_i / in_ready_o   | char_code_i, glyph_bits_i
//   out      | out_valid_o / out_ready_i | command_kind_o .. last_of_char_o
//
// Each character yields 8 results, or 9 when it scrolls the screen; the result
// register sends one per cycle while the result port is not stalled.
// The front classifies a character in the cycle it is accepted; a two-entry
// queue lets it take new characters while the back is still emitting rows.
// Reset restores the register defaults and a zero cursor; no clearing pass.
// A stalled result port holds the result register and backs up into the queue.
module proportional_text_cursor_renderer import ptcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CHAR_W-1:0]      char_code_i,
  input  logic [GLYPH_W-1:0]     glyph_bits_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   command_kind_o,
  output logic [OUT_COORD_W-1:0] pixel_x_o,
  output logic [OUT_COORD_W-1:0] pixel_y_o,
  output logic [MASK_W-1:0]      pixel_mask_o,
  output logic [COLOUR_W-1:0]    paint_colour_o,
  output logic                   last_of_char_o
);

  logic        push_valid, push_ready, pop_valid, pop_ready;
  ptcr_entry_t push_entry, pop_entry;

  // Cursor and classification.
  ptcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .glyph_bits_i (glyph_bits_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // Request queue.
  ptcr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Result sequencing.
  ptcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_entry_i    (pop_entry),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_kind_o (command_kind_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_mask_o   (pixel_mask_o),
    .paint_colour_o (paint_colour_o),
    .last_of_char_o (last_of_char_o)
  );

endmodule

/* hdl/ptcr_checker.sv */
// Port-level checks for the proportional text cursor renderer, bound to the top.
// Depends on ptcr_pkg and proportional_text_cursor_renderer.
module ptcr_checker import ptcr_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   command_kind_o,
  input logic [OUT_COORD_W-1:0] pixel_x_o,
  input logic [MASK_W-1:0]      pixel_mask_o,
  input logic [COLOUR_W-1:0]    paint_colour_o,
  input logic                   last_of_char_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A scroll request carries no pixels and never ends a character.
  a_scroll_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_kind_o == CMD_SCROLL) |->
      !last_of_char_o && (pixel_mask_o == '0) && (paint_colour_o == '0) &&
      (pixel_x_o == '0))
    else $error("scroll request with pixel fields set");

  // A scroll request is followed at once by a glyph row of the same character.
  a_scroll_then_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (command_kind_o == CMD_SCROLL) |=>
      out_valid_o && (command_kind_o == CMD_GLYPH_ROW))
    else $error("scroll request not followed by a glyph row");

  // Results of one character come without gaps.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_char_o |=> out_valid_o)
    else $error("gap inside a character's results");

endmodule

bind proportional_text_cursor_renderer ptcr_checker u_ptcr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .command_kind_o (command_kind_o),
  .pixel_x_o      (pixel_x_o),
  .pixel_mask_o   (pixel_mask_o),
  .paint_colour_o (paint_colour_o),
  .last_of_char_o (last_of_char_o)
);

/* bench/ptcr_render_checker.sv */
`timescale 1ns / 100ps
// Result checker for the proportional text cursor renderer: follows the register,
// character and result channels, predicts every result and compares it in order.
// Depends on ptcr_pkg.
module ptcr_render_checker import ptcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [CHAR_W-1:0]      char_code_i,
  input  logic [GLYPH_W-1:0]     glyph_bits_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   command_kind_i,
  input  logic [OUT_COORD_W-1:0] pixel_x_i,
  input  logic [OUT_COORD_W-1:0] pixel_y_i,
  input  logic [MASK_W-1:0]      pixel_mask_i,
  input  logic [COLOUR_W-1:0]    paint_colour_i,
  input  logic                   last_of_char_i,
  output int                     errors_o,
  output int                     pending_o
);

  // One drawing command as it leaves the block.
  typedef struct packed {
    logic                   kind;
    logic [OUT_COORD_W-1:0] x;
    logic [OUT_COORD_W-1:0] y;
    logic [MASK_W-1:0]      mask;
    logic [COLOUR_W-1:0]    colour;
    logic                   last;
  } draw_cmd_t;

  // Shadow copy of the registers and of the text cursor.
  logic [LIMIT_W-1:0]     wrap_column;
  logic [LIMIT_W-1:0]     scroll_row;
  logic [COLOUR_W-1:0]    ink;
  logic [COORD_WIDTH-1:0] cursor_col;
  logic [COORD_WIDTH-1:0] cursor_row;

  draw_cmd_t draw_cmds_q[$];
  int        mismatches = 0;
  int        backlog = 0;

  assign errors_o  = mismatches;
  assign pending_o = backlog;

  // Spacing of a glyph: its rightmost lit column plus two; blank glyphs take five.
  function automatic logic [ADV_W-1:0] glyph_spacing(input logic [MASK_W-1:0] lit_cols);
    int right_col;
    right_col = 3;
    for (int b = 0; b < MASK_W; b++) begin
      if (lit_cols[b]) right_col = b;
    end
    return ADV_W'(right_col + 2);
  endfunction

  // Moves the cursor for one character and queues the commands it draws.
  task automatic draw_char(input logic [CHAR_W-1:0] code, input logic [GLYPH_W-1:0] glyph);
    draw_cmd_t         cmd;
    logic [MASK_W-1:0] lit_cols;
    lit_cols = '0;
    if (code == CHAR_NEWLINE) begin
      cursor_col = '0;
      cursor_row = cursor_row + LINE_STEP;
    end
    if (cursor_col >= COORD_WIDTH'(wrap_column)) begin
      cursor_col = '0;
      cursor_row = cursor_row + LINE_STEP;
    end
    // Past the bottom: step back one line and clear it.
    if (cursor_row >= COORD_WIDTH'(scroll_row)) begin
      cursor_col = '0;
      cursor_row = cursor_row - LINE_STEP;
      cmd.kind   = CMD_SCROLL;
      cmd.x      = '0;
      cmd.y      = OUT_COORD_W'(cursor_row);
      cmd.mask   = '0;
      cmd.colour = '0;
      cmd.last   = 1'b0;
      draw_cmds_q.push_back(cmd);
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      cmd.kind   = CMD_GLYPH_ROW;
      cmd.x      = OUT_COORD_W'(cursor_col);
      cmd.y      = OUT_COORD_W'(cursor_row) + OUT_COORD_W'(r);
      cmd.mask   = glyph[MASK_W*r +: MASK_W];
      cmd.colour = ink;
      cmd.last   = (r == GLYPH_ROWS - 1);
      lit_cols   = lit_cols | cmd.mask;
      draw_cmds_q.push_back(cmd);
    end
    cursor_col = cursor_col + COORD_WIDTH'(glyph_spacing(lit_cols));
  endtask

  // Sample all three channels at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    draw_cmd_t got;
    draw_cmd_t want;
    if (!rst_ni) begin
      wrap_column = MAX_COLUMN_RST;
      scroll_row  = MAX_ROW_RST;
      ink         = INK_COLOUR_RST;
      cursor_col  = '0;
      cursor_row  = '0;
      draw_cmds_q.delete();
    end else begin
      // Compare a delivered result with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        got.kind   = command_kind_i;
        got.x      = pixel_x_i;
        got.y      = pixel_y_i;
        got.mask   = pixel_mask_i;
        got.colour = paint_colour_i;
        got.last   = last_of_char_i;
        if (draw_cmds_q.size() == 0) begin
          $display("%0t: unexpected result, expected none", $time);
          $display("%0t:   actual kind %0d x %0d y %0d mask %h colour %h last %0d",
                   $time, got.kind, got.x, got.y, got.mask, got.colour, got.last);
          mismatches++;
        end else begin
          want = draw_cmds_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch", $time);
            $display("%0t:   expected kind %0d x %0d y %0d mask %h colour %h last %0d",
                     $time, want.kind, want.x, want.y, want.mask, want.colour, want.last);
            $display("%0t:   actual   kind %0d x %0d y %0d mask %h colour %h last %0d",
                     $time, got.kind, got.x, got.y, got.mask, got.colour, got.last);
            mismatches++;
          end
        end
      end
      // Register writes only arrive while the block is idle.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_COLUMN: wrap_column = cfg_data_i[LIMIT_W-1:0];
          REG_MAX_ROW:    scroll_row  = cfg_data_i[LIMIT_W-1:0];
          REG_INK_COLOUR: ink         = cfg_data_i[COLOUR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) draw_char(char_code_i, glyph_bits_i);
    end
    backlog = draw_cmds_q.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Top of the renderer testbench: clock, reset, character and register requests, and
// a randomly stalling result sink. Depends on ptcr_pkg, the renderer and ptcr_render_checker.
module tb_top;
  import ptcr_pkg::*;

  // Index past the last register; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam int PHASES       = 8;
  localparam int PHASE_CHARS  = 55;
  localparam int LONG_HOLD    = 120;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [CHAR_W-1:0]      char_code;
  logic [GLYPH_W-1:0]     glyph_bits;
  logic                   out_valid;
  logic                   out_ready;
  logic                   command_kind;
  logic [OUT_COORD_W-1:0] pixel_x;
  logic [OUT_COORD_W-1:0] pixel_y;
  logic [MASK_W-1:0]      pixel_mask;
  logic [COLOUR_W-1:0]    paint_colour;
  logic                   last_of_char;

  int errors;
  int pending;
  bit idle_on = 1'b1;
  int long_hold_req = 0;

  proportional_text_cursor_renderer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .glyph_bits_i   (glyph_bits),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .command_kind_o (command_kind),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_mask_o   (pixel_mask),
    .paint_colour_o (paint_colour),
    .last_of_char_o (last_of_char)
  );

  ptcr_render_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .char_code_i    (char_code),
    .glyph_bits_i   (glyph_bits),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .command_kind_i (command_kind),
    .pixel_x_i      (pixel_x),
    .pixel_y_i      (pixel_y),
    .pixel_mask_i   (pixel_mask),
    .paint_colour_i (paint_colour),
    .last_of_char_i (last_of_char),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one character request, then sometimes leaves a gap after it.
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic [GLYPH_W-1:0] glyph);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    char_code  <= code;
    glyph_bits <= glyph;
    do @(posedge clk); while (!in_ready);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering characters and waits until every predicted result is out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // Result sink: random ready bursts, plus one long hold on request.
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req != holds_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_done++;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [CHAR_W-1:0]     code;
    logic [GLYPH_W-1:0]    glyph;
    logic [CFG_DATA_W-1:0] col_lim;
    logic [CFG_DATA_W-1:0] row_lim;
    logic [CFG_DATA_W-1:0] ink;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    char_code  = '0;
    glyph_bits = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset limits: blank, full and edge-column glyphs, newlines that still draw.
    send_char(8'h41, 64'h0000_0000_0000_0000);
    send_char(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_char(8'h00, 64'h8000_0000_0000_0000);
    send_char(8'h7F, 64'h0000_0000_0000_0001);
    send_char(CHAR_NEWLINE, 64'h0102_0408_1020_4080);
    send_char(CHAR_NEWLINE, 64'h0000_0000_0000_0000);
    send_char(8'h20, 64'h5555_5555_5555_5555);
    send_char(8'h80, 64'hAAAA_AAAA_AAAA_AAAA);
    send_char(8'h0B, 64'h00FF_0000_0000_FF00);

    // A tiny screen so that wrapping and scrolling show up at once.
    wait_drained();
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_MAX_COLUMN, 16'd16);
    write_reg(REG_MAX_ROW, 16'hFC10);
    write_reg(REG_INK_COLOUR, 16'h1234);
    send_char(8'h41, 64'hFFFF_FFFF_FFFF_FFFF);
    send_char(8'h42, 64'hFFFF_FFFF_FFFF_FFFF);
    send_char(8'h43, 64'hFFFF_FFFF_FFFF_FFFF);
    send_char(CHAR_NEWLINE, 64'h1818_1818_1818_1818);
    send_char(CHAR_NEWLINE, 64'h0000_0000_0000_0000);
    send_char(8'h2E, 64'h0000_0000_0000_0100);
    send_char(8'h2E, 64'h0000_0000_0000_0000);
    send_char(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_char(CHAR_NEWLINE, 64'h8080_8080_8080_8080);

    // Random phases, each under its own screen size and ink.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == PHASES - 1) idle_on = 1'b0;
      case (p)
        0: begin
          col_lim = 16'd1023;
          row_lim = 16'd1023;
          ink     = 16'h0000;
        end
        1: begin
          col_lim = 16'd0;
          row_lim = 16'd1023;
          ink     = 16'($urandom);
        end
        2: begin
          col_lim = 16'($urandom_range(8, 96));
          row_lim = 16'd8;
          ink     = 16'hFFFF;
        end
        3: begin
          col_lim = 16'($urandom_range(40, 200));
          row_lim = 16'd0;
          ink     = 16'($urandom);
        end
        default: begin
          col_lim = {6'($urandom), 10'($urandom_range(0, 400))};
          row_lim = {6'($urandom), 10'($urandom_range(8, 300))};
          ink     = 16'($urandom);
        end
      endcase
      write_reg(REG_MAX_COLUMN, col_lim);
      write_reg(REG_MAX_ROW, row_lim);
      write_reg(REG_INK_COLOUR, ink);
      // Hold the sink off while characters keep coming, to back up the queue.
      if (p == 0) long_hold_req++;
      for (int i = 0; i < PHASE_CHARS; i++) begin
        if (p == 2 && i == PHASE_CHARS / 2) wait_drained();
        code = ($urandom_range(0, 9) < 2) ? CHAR_NEWLINE : CHAR_W'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
          0: glyph = '0;
          1: glyph = GLYPH_W'($urandom_range(0, 255)) << (8 * $urandom_range(0, 7));
          2: glyph = {$urandom, $urandom} & {8{8'hFF >> $urandom_range(0, 7)}};
          default: glyph = {$urandom, $urandom};
        endcase
        send_char(code, glyph);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
